/* hw/rtl/nbcr_pkg.sv */
// ----------------------------------------------------------------------------
// nbcr_pkg
// Shared widths, codes and word types of the NV21 cover-fit bilinear resizer.
// ----------------------------------------------------------------------------
package nbcr_pkg;

  localparam int SRC_DIM_W  = 10;
  localparam int DST_DIM_W  = 13;
  localparam int INV_W      = 24;
  localparam int OFF_W      = 13;
  localparam int PLANE_W    = 2 * SRC_DIM_W;
  localparam int PROD_W     = DST_DIM_W + SRC_DIM_W;
  localparam int UPOS_W     = 14;
  localparam int RADDR_W    = 2 * SRC_DIM_W + 2;
  localparam int SRC_ADDR_W = 19;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_SRC_WIDTH  = 512;
  localparam int DEF_MAX_SRC_HEIGHT = 512;
  localparam int DEF_MAX_DST_DIM    = 4096;
  localparam int DEF_FRAC_BITS      = 16;

  localparam logic [SRC_DIM_W-1:0] RST_SRC_WIDTH  = 10'd512;
  localparam logic [SRC_DIM_W-1:0] RST_SRC_HEIGHT = 10'd512;
  localparam logic [DST_DIM_W-1:0] RST_DST_WIDTH  = 13'd256;
  localparam logic [DST_DIM_W-1:0] RST_DST_HEIGHT = 13'd256;

  localparam logic [INV_W-1:0] INV_MAX = '1;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CH_LUMA = 2'd0;
  localparam logic [1:0] CH_V    = 2'd1;
  localparam logic [1:0] CH_U    = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_SRC_WIDTH  = 2'd0;
  localparam cfg_index_t CFG_SRC_HEIGHT = 2'd1;
  localparam cfg_index_t CFG_DST_WIDTH  = 2'd2;
  localparam cfg_index_t CFG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic                  op;
    logic [SRC_ADDR_W-1:0] src_addr;
    logic [7:0]            src_byte;
    logic [COORD_W-1:0]    dst_col;
    logic [COORD_W-1:0]    dst_row;
    logic [1:0]            channel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       range_error;
  } out_word_t;

  typedef struct packed {
    logic [SRC_DIM_W-1:0] src_width;
    logic [SRC_DIM_W-1:0] src_height;
    logic [DST_DIM_W-1:0] dst_width;
    logic [DST_DIM_W-1:0] dst_height;
  } nbcr_cfg_t;

  typedef struct packed {
    logic [INV_W-1:0]     inverse_scale;
    logic [OFF_W-1:0]     offset_horiz;
    logic [OFF_W-1:0]     offset_vert;
    logic [PLANE_W-1:0]   plane_size;
    logic [DST_DIM_W-1:0] dst_w;
    logic [DST_DIM_W-1:0] dst_h;
  } nbcr_scale_t;

endpackage

/* hw/rtl/nv21_bilinear_cover_resize.sv */
// ----------------------------------------------------------------------------
// nv21_bilinear_cover_resize
// Cover-fit bilinear resize of an NV21 frame held in an on-chip frame store.
//
// A load word (op 0) writes one source byte and does not raise busy, so loads
// can be issued every cycle while busy is low. A query word (op 1) returns one
// destination byte after the two position multiplies, the row multiply and
// the four neighbor reads through the single port of the frame memory followed
// by two interpolation steps, with busy high meanwhile. A query that lies
// outside its plane, or names channel three, returns range_error in the cycle
// after acceptance. Each result is shown for exactly one cycle with out_valid
// and cannot be held off. After reset and after every configuration write the
// settings are re-derived, during which busy is high and cfg_ready is low.
// The frame store is not cleared; read only what was loaded.
// ----------------------------------------------------------------------------
module nv21_bilinear_cover_resize #(
  parameter int MAX_SRC_WIDTH  = nbcr_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = nbcr_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_DIM    = nbcr_pkg::DEF_MAX_DST_DIM,
  parameter int FRAC_BITS      = nbcr_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  nbcr_pkg::in_word_t                  in_word,
  output logic                                busy,
  output logic                                out_valid,
  output nbcr_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  nbcr_pkg::cfg_index_t                cfg_index,
  input  logic [nbcr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nbcr_pkg::*;

  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * 3 / 2;
  localparam int MEM_AW      = $clog2(STORE_DEPTH);
  localparam int POS_W       = UPOS_W + INV_W;
  localparam int IDX_W       = POS_W - FRAC_BITS;
  localparam int TOP_W       = FRAC_BITS + 8;

  typedef enum logic [9:0] {
    Q_IDLE = 10'b0000000001,
    Q_MX   = 10'b0000000010,
    Q_MY   = 10'b0000000100,
    Q_ROW  = 10'b0000001000,
    Q_RA   = 10'b0000010000,
    Q_RB   = 10'b0000100000,
    Q_RC   = 10'b0001000000,
    Q_RD   = 10'b0010000000,
    Q_WD   = 10'b0100000000,
    Q_FIN  = 10'b1000000000
  } q_state_t;

  q_state_t    q_state_r, q_state_nxt;
  nbcr_cfg_t   cfg_r, cfg_nxt;
  logic        drv_start_r, drv_start_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r;
  nbcr_scale_t scale;
  logic        drv_busy, deriving, cfg_wr, accept, is_query, q_err, q_chroma;

  logic [UPOS_W-1:0]    ux_r, uy_r;
  logic                 chroma_r, ch_u_r;
  logic [POS_W-1:0]     pos_r;
  logic [SRC_DIM_W-1:0] x0_r, x1_r;
  logic [FRAC_BITS-1:0] dx_r, dy_r;
  logic [RADDR_W-1:0]   row0_r, row1_r;
  logic                 rstep_r;
  logic [7:0]           a_r, c_r;
  logic [TOP_W-1:0]     top_r, bot_r;

  logic [7:0]           frame_store [STORE_DEPTH];
  logic [7:0]           rd_data_r;
  logic                 rd_ok_r;

  // position split
  logic [SRC_DIM_W-1:0] sp_dim, sp_half, sp_lim, sp_idx, sp_nxt;
  logic [IDX_W-1:0]     sp_full;
  logic [FRAC_BITS-1:0] sp_fraw, sp_frac;
  logic                 sp_at_lim;

  // addressing
  logic [2*SRC_DIM_W-1:0] yprod;
  logic [RADDR_W-1:0]     base, row_sel, raddr;
  logic [SRC_DIM_W-1:0]   x_sel;
  logic [SRC_DIM_W:0]     x_off;
  logic                   rd_en, rd_ok, mem_we;
  logic [MEM_AW-1:0]      mem_addr;
  logic [7:0]             rdv;

  // interpolation
  logic [7:0]                  lo;
  logic signed [8:0]           ldiff;
  logic signed [FRAC_BITS+9:0] lprod, lsum;
  logic signed [TOP_W:0]       fdiff;
  logic signed [2*FRAC_BITS+9:0] fprod, fsum;

  nbcr_derive #(
    .MAX_DST_DIM (MAX_DST_DIM),
    .FRAC_BITS   (FRAC_BITS)
  ) u_derive (
    .clk   (clk),
    .rst_n (rst_n),
    .start (drv_start_r),
    .cfg   (cfg_r),
    .busy  (drv_busy),
    .scale (scale)
  );

  assign deriving  = drv_busy || drv_start_r;
  assign busy      = deriving || (q_state_r != Q_IDLE);
  assign cfg_ready = !deriving;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;
  assign is_query  = in_word.op == OP_QUERY;

  always_comb begin
    q_chroma = in_word.channel inside {CH_V, CH_U};
    if (in_word.channel == CH_LUMA) begin
      q_err = ({1'b0, in_word.dst_col} >= scale.dst_w) ||
              ({1'b0, in_word.dst_row} >= scale.dst_h);
    end else if (q_chroma) begin
      q_err = ({1'b0, in_word.dst_col} >= {1'b0, scale.dst_w[DST_DIM_W-1:1]}) ||
              ({1'b0, in_word.dst_row} >= {1'b0, scale.dst_h[DST_DIM_W-1:1]});
    end else begin
      q_err = 1'b1;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  cfg_nxt.src_width  = cfg_data[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT: cfg_nxt.src_height = cfg_data[SRC_DIM_W-1:0];
        CFG_DST_WIDTH:  cfg_nxt.dst_width  = cfg_data[DST_DIM_W-1:0];
        CFG_DST_HEIGHT: cfg_nxt.dst_height = cfg_data[DST_DIM_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
    drv_start_nxt = cfg_wr;
  end

  always_comb begin
    q_state_nxt   = q_state_r;
    out_valid_nxt = 1'b0;
    case (q_state_r)
      Q_IDLE: begin
        if (accept && is_query) begin
          if (q_err) out_valid_nxt = 1'b1;
          else q_state_nxt = Q_MX;
        end
      end
      Q_MX:  q_state_nxt = Q_MY;
      Q_MY:  q_state_nxt = Q_ROW;
      Q_ROW: q_state_nxt = Q_RA;
      Q_RA:  q_state_nxt = Q_RB;
      Q_RB:  q_state_nxt = Q_RC;
      Q_RC:  q_state_nxt = Q_RD;
      Q_RD:  q_state_nxt = Q_WD;
      Q_WD:  q_state_nxt = Q_FIN;
      Q_FIN: begin
        out_valid_nxt = 1'b1;
        q_state_nxt   = Q_IDLE;
      end
      default: q_state_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_state_r   <= Q_IDLE;
      out_valid_r <= 1'b0;
      drv_start_r <= 1'b1;
      cfg_r       <= '{src_width:  RST_SRC_WIDTH,  src_height: RST_SRC_HEIGHT,
                       dst_width:  RST_DST_WIDTH,  dst_height: RST_DST_HEIGHT};
    end else begin
      q_state_r   <= q_state_nxt;
      out_valid_r <= out_valid_nxt;
      drv_start_r <= drv_start_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // split a mapped position into index, fraction and clamped neighbor
  always_comb begin
    sp_dim  = (q_state_r == Q_MY) ? cfg_r.src_width : cfg_r.src_height;
    sp_half = sp_dim >> 1;
    if (chroma_r) sp_lim = (sp_half != '0) ? sp_half - 1'b1 : '0;
    else sp_lim = (sp_dim != '0) ? sp_dim - 1'b1 : '0;
    sp_full   = chroma_r ? IDX_W'(pos_r >> (FRAC_BITS + 1)) : IDX_W'(pos_r >> FRAC_BITS);
    sp_fraw   = chroma_r ? pos_r[FRAC_BITS:1] : pos_r[FRAC_BITS-1:0];
    sp_idx    = (sp_full > IDX_W'(sp_lim)) ? sp_lim : sp_full[SRC_DIM_W-1:0];
    sp_frac   = (sp_full > IDX_W'(sp_lim)) ? '0 : sp_fraw;
    sp_at_lim = sp_idx == sp_lim;
    sp_nxt    = sp_at_lim ? sp_lim : sp_idx + 1'b1;
  end

  always_comb begin
    yprod   = sp_idx * cfg_r.src_width;
    base    = chroma_r ? RADDR_W'(scale.plane_size) + RADDR_W'(ch_u_r) : '0;
    x_sel   = ((q_state_r == Q_RA) || (q_state_r == Q_RC)) ? x0_r : x1_r;
    x_off   = chroma_r ? {x_sel, 1'b0} : {1'b0, x_sel};
    row_sel = ((q_state_r == Q_RA) || (q_state_r == Q_RB)) ? row0_r : row1_r;
    raddr   = row_sel + RADDR_W'(x_off);
    rd_ok   = 32'(raddr) < 32'(STORE_DEPTH);
    rd_en   = (q_state_r == Q_RA) || (q_state_r == Q_RB) ||
              (q_state_r == Q_RC) || (q_state_r == Q_RD);
    mem_we  = accept && !is_query && (32'(in_word.src_addr) < 32'(STORE_DEPTH));
    mem_addr = rd_en ? MEM_AW'(raddr) : MEM_AW'(in_word.src_addr);
    rdv     = rd_ok_r ? rd_data_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_store[mem_addr] <= in_word.src_byte;
    if (rd_en) begin
      rd_data_r <= frame_store[mem_addr];
      rd_ok_r   <= rd_ok;
    end
  end

  // one horizontal lerp per step, then the vertical blend
  always_comb begin
    lo    = (q_state_r == Q_RC) ? a_r : c_r;
    ldiff = $signed({1'b0, rdv}) - $signed({1'b0, lo});
    lprod = ldiff * $signed({1'b0, dx_r});
    lsum  = $signed({2'b00, lo, {FRAC_BITS{1'b0}}}) + lprod;
    fdiff = $signed({1'b0, bot_r}) - $signed({1'b0, top_r});
    fprod = fdiff * $signed({1'b0, dy_r});
    fsum  = $signed({2'b00, top_r, {FRAC_BITS{1'b0}}}) + fprod;
  end

  always_ff @(posedge clk) begin
    case (q_state_r)
      Q_IDLE: begin
        if (accept && is_query) begin
          out_word_r <= '{out_byte: 8'd0, range_error: 1'b1};
          chroma_r   <= q_chroma;
          ch_u_r     <= in_word.channel == CH_U;
          if (q_chroma) begin
            ux_r <= UPOS_W'({in_word.dst_col, 1'b0}) + UPOS_W'(scale.offset_horiz);
            uy_r <= UPOS_W'({in_word.dst_row, 1'b0}) + UPOS_W'(scale.offset_vert);
          end else begin
            ux_r <= UPOS_W'(in_word.dst_col) + UPOS_W'(scale.offset_horiz);
            uy_r <= UPOS_W'(in_word.dst_row) + UPOS_W'(scale.offset_vert);
          end
        end
      end
      Q_MX: pos_r <= ux_r * scale.inverse_scale;
      Q_MY: begin
        x0_r  <= sp_idx;
        x1_r  <= sp_nxt;
        dx_r  <= sp_frac;
        pos_r <= uy_r * scale.inverse_scale;
      end
      Q_ROW: begin
        dy_r    <= sp_frac;
        rstep_r <= !sp_at_lim;
        row0_r  <= base + RADDR_W'(yprod);
      end
      Q_RA: row1_r <= row0_r + (rstep_r ? RADDR_W'(cfg_r.src_width) : '0);
      Q_RB: a_r    <= rdv;
      Q_RC: top_r  <= lsum[TOP_W-1:0];
      Q_RD: c_r    <= rdv;
      Q_WD: bot_r  <= lsum[TOP_W-1:0];
      Q_FIN: out_word_r <= '{out_byte: fsum[2*FRAC_BITS+7:2*FRAC_BITS], range_error: 1'b0};
      default: out_word_r <= out_word_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_query) |=> (out_valid || busy))
    else $error("query neither answered nor in progress");

  a_fin_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (q_state_r == Q_FIN) |=> (out_valid && !out_word.range_error))
    else $error("interpolated result not delivered");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.range_error) |-> (out_word.out_byte == 8'd0))
    else $error("range error with nonzero byte");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !mem_we)
    else $error("frame store read and write collide");

  a_no_derive_query: assert property (@(posedge clk) disable iff (!rst_n)
    (q_state_r != Q_IDLE) |-> !deriving)
    else $error("settings change during a query");
`endif

endmodule

/* hw/rtl/nbcr_derive.sv */
// ----------------------------------------------------------------------------
// nbcr_derive
// Derives even destination sizes, plane size, inverse scale and crop offsets
// from the size registers, using a shared restoring divider one bit per cycle.
// ----------------------------------------------------------------------------
module nbcr_derive #(
  parameter int MAX_DST_DIM = nbcr_pkg::DEF_MAX_DST_DIM,
  parameter int FRAC_BITS   = nbcr_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  nbcr_pkg::nbcr_cfg_t cfg,
  output logic                busy,
  output nbcr_pkg::nbcr_scale_t scale
);
  import nbcr_pkg::*;

  localparam int NUM_W   = (SRC_DIM_W + FRAC_BITS > PROD_W) ? SRC_DIM_W + FRAC_BITS : PROD_W;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int CMP_W   = NUM_W + INV_W;
  localparam int DST_LIM = MAX_DST_DIM & ~1;

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_P1   = 6'b000010,
    D_P2   = 6'b000100,
    D_P3   = 6'b001000,
    D_DIV1 = 6'b010000,
    D_DIV2 = 6'b100000
  } drv_state_t;

  drv_state_t           state_r, state_nxt;
  logic [PROD_W-1:0]    p1_r, p1_nxt, p2_r, p2_nxt;
  logic                 gov_r, gov_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt, quo_r, quo_nxt;
  logic [DST_DIM_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  nbcr_scale_t          scale_r, scale_nxt;

  logic [DST_DIM_W-1:0] dw_m, dh_m, dw_e, dh_e, other;
  logic [DST_DIM_W:0]   trial, trial_sub;
  logic                 ge, gov_c, degen;
  logic [DST_DIM_W-1:0] rem_step;
  logic [NUM_W-1:0]     quo_step, ox, off_raw;
  logic [CMP_W-1:0]     q_ext;
  logic [INV_W-1:0]     inv_sat;
  logic [OFF_W-1:0]     off_sat;

  always_comb begin
    dw_m = {cfg.dst_width[DST_DIM_W-1:1], 1'b0};
    dh_m = {cfg.dst_height[DST_DIM_W-1:1], 1'b0};
    dw_e = (32'(dw_m) > 32'(DST_LIM)) ? DST_DIM_W'(DST_LIM) : dw_m;
    dh_e = (32'(dh_m) > 32'(DST_LIM)) ? DST_DIM_W'(DST_LIM) : dh_m;

    trial     = {rem_r, num_r[NUM_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = trial >= {1'b0, den_r};
    rem_step  = ge ? trial_sub[DST_DIM_W-1:0] : trial[DST_DIM_W-1:0];
    quo_step  = {quo_r[NUM_W-2:0], ge};

    q_ext   = CMP_W'(quo_step);
    inv_sat = (q_ext > CMP_W'(INV_MAX)) ? INV_MAX : INV_W'(quo_step);

    other   = gov_r ? scale_r.dst_h : scale_r.dst_w;
    ox      = NUM_W'(other);
    off_raw = (quo_step >= ox) ? ((quo_step - ox) >> 1) : '0;
    off_sat = (off_raw > NUM_W'(OFF_MAX)) ? OFF_MAX : off_raw[OFF_W-1:0];

    gov_c = p1_r >= p2_r;
    degen = (cfg.src_width == '0) || (cfg.src_height == '0) ||
            (scale_r.dst_w == '0) || (scale_r.dst_h == '0);
  end

  always_comb begin
    state_nxt = state_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    gov_nxt   = gov_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    scale_nxt = scale_r;
    case (state_r)
      D_IDLE: begin
        if (start) state_nxt = D_P1;
      end
      D_P1: begin
        scale_nxt.dst_w = dw_e;
        scale_nxt.dst_h = dh_e;
        p1_nxt          = dw_e * cfg.src_height;
        state_nxt       = D_P2;
      end
      D_P2: begin
        p2_nxt               = scale_r.dst_h * cfg.src_width;
        scale_nxt.plane_size = cfg.src_width * cfg.src_height;
        state_nxt            = D_P3;
      end
      D_P3: begin
        gov_nxt = gov_c;
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = CNT_W'(NUM_W - 1);
        num_nxt = gov_c ? NUM_W'({cfg.src_width, {FRAC_BITS{1'b0}}})
                        : NUM_W'({cfg.src_height, {FRAC_BITS{1'b0}}});
        den_nxt = gov_c ? scale_r.dst_w : scale_r.dst_h;
        if (degen) begin
          scale_nxt.inverse_scale = '0;
          scale_nxt.offset_horiz  = '0;
          scale_nxt.offset_vert   = '0;
          state_nxt               = D_IDLE;
        end else begin
          state_nxt = D_DIV1;
        end
      end
      D_DIV1: begin
        num_nxt = num_r << 1;
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          scale_nxt.inverse_scale = inv_sat;
          rem_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(NUM_W - 1);
          num_nxt   = gov_r ? NUM_W'(p1_r) : NUM_W'(p2_r);
          den_nxt   = gov_r ? DST_DIM_W'(cfg.src_width) : DST_DIM_W'(cfg.src_height);
          state_nxt = D_DIV2;
        end
      end
      D_DIV2: begin
        num_nxt = num_r << 1;
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          scale_nxt.offset_horiz = gov_r ? '0 : off_sat;
          scale_nxt.offset_vert  = gov_r ? off_sat : '0;
          state_nxt              = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      scale_r <= '0;
    end else begin
      state_r <= state_nxt;
      scale_r <= scale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    gov_r <= gov_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy  = state_r != D_IDLE;
  assign scale = scale_r;

endmodule

/* bench/nv21_bilinear_cover_resize_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv21_bilinear_cover_resize_test
// Self-checking bench for the NV21 cover-fit bilinear resizer. A driver feeds
// load and query words from a pending queue. It predicts each query's byte
// from a shadow frame store and a shadow copy of the derived scale and crop.
// A monitor compares every result strobe with the oldest prediction. Phases
// reprogram the four size registers with minimum, maximum, degenerate, odd and
// random values, and vary the sender's idle rate. Source bytes are loaded on
// demand, so a query never reads a store entry that was never written.
// ----------------------------------------------------------------------------
module nv21_bilinear_cover_resize_test;
  import nbcr_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam int STORE_DEPTH = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT * 3 / 2;
  localparam longint unsigned UNIT = 64'd1 << FRAC;
  localparam longint unsigned FRAC_MASK = UNIT - 1;
  localparam longint unsigned DIM_LIMIT = DEF_MAX_DST_DIM & ~1;
  localparam logic [1:0] CH_INVALID = 2'd3;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic               err;
    logic [RADDR_W-1:0] a;
    logic [RADDR_W-1:0] b;
    logic [RADDR_W-1:0] c;
    logic [RADDR_W-1:0] d;
    logic [FRAC-1:0]    dx;
    logic [FRAC-1:0]    dy;
  } taps_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  in_word_t              in_word = '0;
  logic                  busy;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = CFG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nv21_bilinear_cover_resize uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [SRC_DIM_W-1:0] src_w_reg, src_h_reg;
  logic [DST_DIM_W-1:0] dst_w_reg, dst_h_reg;
  logic [INV_W-1:0]     inv_q;
  logic [OFF_W-1:0]     off_h, off_v;

  logic [7:0]  frame_shadow [STORE_DEPTH];
  bit          filled [STORE_DEPTH];
  in_word_t    pending_words [$];
  out_word_t   expected_pixels [$];
  out_word_t   head_pixel;
  int unsigned send_idle_pct = 0;
  int unsigned mismatch_count = 0;

  always #5 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint unsigned even_size(logic [DST_DIM_W-1:0] v);
    longint unsigned e;
    e = v & 13'h1FFE;
    return (e > DIM_LIMIT) ? DIM_LIMIT : e;
  endfunction

  function automatic logic [OFF_W-1:0] clip_offset(longint unsigned v);
    return (v > OFF_MAX) ? OFF_MAX : v[OFF_W-1:0];
  endfunction

  function automatic void rederive();
    longint unsigned sw, sh, dw, dh, q, scaled;
    sw = src_w_reg;
    sh = src_h_reg;
    dw = even_size(dst_w_reg);
    dh = even_size(dst_h_reg);
    inv_q = '0;
    off_h = '0;
    off_v = '0;
    if (sw == 0 || sh == 0 || dw == 0 || dh == 0) return;
    if (dw * sh >= dh * sw) begin
      q = (sw << FRAC) / dw;
      scaled = sh * dw / sw;
      off_v = clip_offset(scaled >= dh ? (scaled - dh) / 2 : 0);
    end else begin
      q = (sh << FRAC) / dh;
      scaled = sw * dh / sh;
      off_h = clip_offset(scaled >= dw ? (scaled - dw) / 2 : 0);
    end
    inv_q = (q > INV_MAX) ? INV_MAX : q[INV_W-1:0];
  endfunction

  function automatic taps_t neighbor_taps(in_word_t w);
    taps_t t;
    longint unsigned dw, dh, px, py, xl, yl, base, step, x0, y0, x1, y1, fx, fy, addr;
    int unsigned extra;
    t = '0;
    dw = even_size(dst_w_reg);
    dh = even_size(dst_h_reg);
    px = 0;
    py = 0;
    xl = 0;
    yl = 0;
    base = 0;
    step = 1;
    extra = 0;
    if (w.channel == CH_LUMA) begin
      t.err = (w.dst_col >= dw) || (w.dst_row >= dh);
      px = w.dst_col;
      px = (px + off_h) * inv_q;
      py = w.dst_row;
      py = (py + off_v) * inv_q;
      xl = (src_w_reg != 0) ? src_w_reg - 1 : 0;
      yl = (src_h_reg != 0) ? src_h_reg - 1 : 0;
    end else if (w.channel == CH_V || w.channel == CH_U) begin
      t.err = (w.dst_col >= dw / 2) || (w.dst_row >= dh / 2);
      px = w.dst_col;
      px = (2 * px + off_h) * inv_q;
      py = w.dst_row;
      py = (2 * py + off_v) * inv_q;
      xl = (src_w_reg / 2 != 0) ? src_w_reg / 2 - 1 : 0;
      yl = (src_h_reg / 2 != 0) ? src_h_reg / 2 - 1 : 0;
      base = src_w_reg;
      base = base * src_h_reg + ((w.channel == CH_V) ? 0 : 1);
      step = 2;
      extra = 1;
    end else begin
      t.err = 1'b1;
    end
    if (!t.err) begin
      x0 = px >> (FRAC + extra);
      fx = (px >> extra) & FRAC_MASK;
      if (x0 > xl) begin
        x0 = xl;
        fx = 0;
      end
      y0 = py >> (FRAC + extra);
      fy = (py >> extra) & FRAC_MASK;
      if (y0 > yl) begin
        y0 = yl;
        fy = 0;
      end
      x1 = (x0 + 1 > xl) ? xl : x0 + 1;
      y1 = (y0 + 1 > yl) ? yl : y0 + 1;
      addr = base + y0 * src_w_reg + x0 * step;
      t.a = addr[RADDR_W-1:0];
      addr = base + y0 * src_w_reg + x1 * step;
      t.b = addr[RADDR_W-1:0];
      addr = base + y1 * src_w_reg + x0 * step;
      t.c = addr[RADDR_W-1:0];
      addr = base + y1 * src_w_reg + x1 * step;
      t.d = addr[RADDR_W-1:0];
      t.dx = fx[FRAC-1:0];
      t.dy = fy[FRAC-1:0];
    end
    return t;
  endfunction

  function automatic longint unsigned stored_byte(logic [RADDR_W-1:0] addr);
    return (addr < STORE_DEPTH) ? frame_shadow[addr] : 0;
  endfunction

  function automatic out_word_t resample_byte(in_word_t w);
    out_word_t r;
    taps_t t;
    longint unsigned top, bot, val;
    r = '0;
    t = neighbor_taps(w);
    if (t.err) begin
      r.range_error = 1'b1;
      return r;
    end
    top = stored_byte(t.a) * (UNIT - t.dx) + stored_byte(t.b) * t.dx;
    bot = stored_byte(t.c) * (UNIT - t.dx) + stored_byte(t.d) * t.dx;
    val = (top * (UNIT - t.dy) + bot * t.dy) >> (2 * FRAC);
    r.out_byte = val[7:0];
    return r;
  endfunction

  function automatic void take_word(in_word_t w);
    if (w.op == OP_LOAD) begin
      if (w.src_addr < STORE_DEPTH) frame_shadow[w.src_addr] = w.src_byte;
    end else begin
      expected_pixels.push_back(resample_byte(w));
    end
  endfunction

  // Feed one word per handshake; hold the word while busy.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) take_word(in_word);
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= pending_words.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: out_byte %0d range_error %0d",
               out_word.out_byte, out_word.range_error);
        mismatch_count++;
      end else begin
        head_pixel = expected_pixels.pop_front();
        if (out_word.out_byte !== head_pixel.out_byte) begin
          $error("out_byte expected %0d actual %0d", head_pixel.out_byte, out_word.out_byte);
          mismatch_count++;
        end
        if (out_word.range_error !== head_pixel.range_error) begin
          $error("range_error expected %0d actual %0d",
                 head_pixel.range_error, out_word.range_error);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic void enqueue_load(logic [SRC_ADDR_W-1:0] addr, logic [7:0] value);
    in_word_t w;
    w.op = OP_LOAD;
    w.src_addr = addr;
    w.src_byte = value;
    w.dst_col = $urandom_range(4095);
    w.dst_row = $urandom_range(4095);
    w.channel = $urandom_range(3);
    pending_words.push_back(w);
    if (addr < STORE_DEPTH) filled[addr] = 1'b1;
  endfunction

  function automatic void touch(logic [RADDR_W-1:0] addr);
    if (addr < STORE_DEPTH && !filled[addr]) enqueue_load(addr[SRC_ADDR_W-1:0], random_byte());
  endfunction

  // Load any neighbor never written before queuing the query itself.
  function automatic void enqueue_query(in_word_t w);
    taps_t t;
    t = neighbor_taps(w);
    if (!t.err) begin
      touch(t.a);
      touch(t.b);
      touch(t.c);
      touch(t.d);
    end
    pending_words.push_back(w);
  endfunction

  function automatic void query_at(logic [1:0] ch, int unsigned col, int unsigned row);
    in_word_t w;
    w.op = OP_QUERY;
    w.src_addr = $urandom_range(19'h7FFFF);
    w.src_byte = $urandom_range(255);
    w.dst_col = col;
    w.dst_row = row;
    w.channel = ch;
    enqueue_query(w);
  endfunction

  function automatic int unsigned near_limit(longint unsigned lim);
    if (lim == 0) return $urandom_range(4095);
    case ($urandom_range(9))
      0: return 0;
      1: return lim - 1;
      2: return (lim > 4095) ? lim - 1 : lim;
      default: return $urandom_range(lim - 1);
    endcase
  endfunction

  function automatic void random_query();
    logic [1:0] ch;
    longint unsigned lim_c, lim_r;
    int unsigned pick;
    pick = $urandom_range(99);
    case ($urandom_range(2))
      0: ch = CH_LUMA;
      1: ch = CH_V;
      default: ch = CH_U;
    endcase
    lim_c = even_size(dst_w_reg);
    lim_r = even_size(dst_h_reg);
    if (ch != CH_LUMA) begin
      lim_c = lim_c / 2;
      lim_r = lim_r / 2;
    end
    if (pick < 5) begin
      query_at(CH_INVALID, $urandom_range(4095), $urandom_range(4095));
    end else if (pick < 15) begin
      query_at(ch, $urandom_range(4095), $urandom_range(4095));
    end else begin
      query_at(ch, near_limit(lim_c), near_limit(lim_r));
    end
  endfunction

  task automatic wait_quiet();
    while (pending_words.size() != 0 || start || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  src_w_reg = value[SRC_DIM_W-1:0];
      CFG_SRC_HEIGHT: src_h_reg = value[SRC_DIM_W-1:0];
      CFG_DST_WIDTH:  dst_w_reg = value;
      CFG_DST_HEIGHT: dst_h_reg = value;
      default: ;
    endcase
    rederive();
  endtask

  task automatic run_phase(logic [SRC_DIM_W-1:0] sw, logic [SRC_DIM_W-1:0] sh,
                           logic [DST_DIM_W-1:0] dw, logic [DST_DIM_W-1:0] dh,
                           int unsigned queries, int unsigned idle_pct);
    logic [CFG_DATA_W-1:0] value;
    longint unsigned region;
    // Drain before touching the registers.
    wait_quiet();
    value = $urandom_range(8191);
    value[SRC_DIM_W-1:0] = sw;
    write_register(CFG_SRC_WIDTH, value);
    value = $urandom_range(8191);
    value[SRC_DIM_W-1:0] = sh;
    write_register(CFG_SRC_HEIGHT, value);
    write_register(CFG_DST_WIDTH, dw);
    write_register(CFG_DST_HEIGHT, dh);
    send_idle_pct = idle_pct;
    region = src_w_reg;
    region = region * src_h_reg * 3 / 2 + src_w_reg + 4;
    if (region > STORE_DEPTH) region = STORE_DEPTH;
    for (int unsigned i = 0; i < queries; i++) begin
      if ($urandom_range(3) == 0) enqueue_load($urandom_range(region - 1), random_byte());
      if ($urandom_range(19) == 0) enqueue_load($urandom_range(19'h7FFFF), random_byte());
      random_query();
    end
  endtask

  initial begin
    logic [SRC_DIM_W-1:0] sw, sh;
    logic [DST_DIM_W-1:0] dw, dh;
    src_w_reg = RST_SRC_WIDTH;
    src_h_reg = RST_SRC_HEIGHT;
    dst_w_reg = RST_DST_WIDTH;
    dst_h_reg = RST_DST_HEIGHT;
    rederive();

    enqueue_load(19'd0, 8'hFF);
    enqueue_load(19'd1, 8'h00);
    enqueue_load(19'h7FFFF, 8'hA5);
    enqueue_load(STORE_DEPTH - 1, 8'h5A);
    query_at(CH_LUMA, 0, 0);
    query_at(CH_LUMA, 255, 255);
    query_at(CH_LUMA, 256, 0);
    query_at(CH_LUMA, 0, 256);
    query_at(CH_LUMA, 4095, 4095);
    query_at(CH_V, 0, 0);
    query_at(CH_U, 0, 0);
    query_at(CH_V, 127, 127);
    query_at(CH_U, 127, 127);
    query_at(CH_V, 128, 0);
    query_at(CH_U, 0, 128);
    query_at(CH_INVALID, 0, 0);

    run_phase(10'd2, 10'd2, 13'd2, 13'd2, 30, 0);
    run_phase(10'd512, 10'd512, 13'd2, 13'd2, 30, 86);
    run_phase(10'd512, 10'd2, 13'd4096, 13'd2, 30, 19);
    run_phase(10'd2, 10'd512, 13'd2, 13'd4096, 30, 0);
    run_phase(10'd0, 10'd6, 13'd10, 13'd10, 25, 86);
    run_phase(10'd6, 10'd4, 13'd1, 13'd8191, 25, 19);
    run_phase(10'd1023, 10'd1023, 13'd8191, 13'd30, 30, 0);
    run_phase(10'd7, 10'd5, 13'd13, 13'd9, 30, 86);

    for (int unsigned p = 0; p < 9; p++) begin
      sw = ($urandom_range(6) == 0) ? $urandom_range(1023) : 2 * $urandom_range(1, 32);
      sh = ($urandom_range(6) == 0) ? $urandom_range(1023) : 2 * $urandom_range(1, 32);
      dw = ($urandom_range(4) == 0) ? $urandom_range(8191) : $urandom_range(2, 300);
      dh = ($urandom_range(4) == 0) ? $urandom_range(8191) : $urandom_range(2, 300);
      case (p % 3)
        0: run_phase(sw, sh, dw, dh, 25, 19);
        1: run_phase(sw, sh, dw, dh, 25, 0);
        default: run_phase(sw, sh, dw, dh, 25, 86);
      endcase
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/nbcr_pkg.sv
hw/rtl/nbcr_derive.sv
hw/rtl/nv21_bilinear_cover_resize.sv
bench/nv21_bilinear_cover_resize_test.sv
